// File: rtl/bounce_easing_curve_assert.svh
// Assertion macros used by the bounce easing top level.
// Each macro expands to one labeled concurrent assertion that is disabled while reset is active.
`ifndef BOUNCE_EASING_CURVE_ASSERT_SVH
`define BOUNCE_EASING_CURVE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BEC_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("bounce easing assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BEC_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
    name: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("bounce easing assertion failed");

`endif

// File: rtl/bec_pkg.sv
`timescale 1ns / 1ps
package bec_pkg;

    localparam int DEF_TIME_BITS  = 16;
    localparam int DEF_VALUE_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_EASE_MODE    = 2'd0,
        REG_START_VALUE  = 2'd1,
        REG_CHANGE_VALUE = 2'd2,
        REG_DURATION     = 2'd3
    } reg_index_t;

    localparam logic [1:0] MODE_OUT    = 2'd0;
    localparam logic [1:0] MODE_IN     = 2'd1;
    localparam logic [1:0] MODE_IN_OUT = 2'd2;

    // How the bounce-out value is folded into the final curve.
    typedef enum logic [1:0] {
        KIND_OUT_FULL = 2'd0,
        KIND_IN_FULL  = 2'd1,
        KIND_IN_HALF  = 2'd2,
        KIND_OUT_HALF = 2'd3
    } curve_kind_t;

    // Parabola center of each segment, in units of 1/22.
    function automatic logic [4:0] bec_seg_k(input logic [1:0] seg);
        logic [4:0] k;
        case (seg)
            2'd0:    k = 5'd0;
            2'd1:    k = 5'd12;
            2'd2:    k = 5'd18;
            default: k = 5'd21;
        endcase
        return k;
    endfunction

    // Height offset of each segment, in units of 1/64.
    function automatic logic [5:0] bec_seg_offset(input logic [1:0] seg);
        logic [5:0] off;
        case (seg)
            2'd0:    off = 6'd0;
            2'd1:    off = 6'd48;
            2'd2:    off = 6'd60;
            default: off = 6'd63;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/bec_divider.sv
`timescale 1ns / 1ps
module bec_divider #(
    parameter int TIME_BITS = bec_pkg::DEF_TIME_BITS,
    parameter int FRAC_BITS = bec_pkg::DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [TIME_BITS-1:0] elapsed,
    input  logic [TIME_BITS-1:0] duration,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS:0]   progress
);
    import bec_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;
    localparam int RW     = TIME_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [STAGES-1:0]    vld_reg;
    logic [STAGES:0]      rdy;
    logic [RW-1:0]        rem_reg  [STAGES];
    logic [RW-1:0]        rem_next [STAGES];
    logic [FRAC_BITS-1:0] quo_reg  [STAGES];
    logic [FRAC_BITS-1:0] quo_next [STAGES];
    logic                 full_reg  [STAGES];
    logic                 full_next [STAGES];
    logic [RW-1:0]        dur_ext;

    assign dur_ext     = {1'b0, duration};
    assign rdy[STAGES] = out_ready;
    assign in_ready    = rdy[0];
    assign out_valid   = vld_reg[STAGES-1];
    assign progress    = full_reg[STAGES-1] ? ONE : {1'b0, quo_reg[STAGES-1]};

    // Stage zero clamps the time; once elapsed reaches the duration the progress is one.
    always_comb
    begin
        full_next[0] = (duration == '0) || (elapsed >= duration);
        rem_next[0]  = full_next[0] ? '0 : {1'b0, elapsed};
        quo_next[0]  = '0;
    end

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            assign rdy[s] = ~vld_reg[s] | rdy[s+1];

            if (s > 0)
            begin : g_step
                logic [RW-1:0] trial;
                logic          take;
                always_comb
                begin
                    trial       = {rem_reg[s-1][RW-2:0], 1'b0};
                    take        = (trial >= dur_ext);
                    rem_next[s] = take ? (trial - dur_ext) : trial;
                    quo_next[s] = {quo_reg[s-1][FRAC_BITS-2:0], take};
                    full_next[s] = full_reg[s-1];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (rdy[s])
                begin
                    vld_reg[s] <= (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s])
                begin
                    rem_reg[s]  <= rem_next[s];
                    quo_reg[s]  <= quo_next[s];
                    full_reg[s] <= full_next[s];
                end
            end
        end
    endgenerate

endmodule

// File: rtl/bec_curve.sv
`timescale 1ns / 1ps
module bec_curve #(
    parameter int FRAC_BITS = bec_pkg::DEF_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FRAC_BITS:0]   progress,
    input  logic [1:0]           ease_mode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS+1:0] curve
);
    import bec_pkg::*;

    localparam int XW = FRAC_BITS + 1;
    localparam int MW = FRAC_BITS + 5;
    localparam int UW = FRAC_BITS + 6;
    localparam int AW = FRAC_BITS + 4;
    localparam int SW = 2 * AW;
    localparam int GW = FRAC_BITS + 2;
    localparam logic [XW-1:0] HALF  = XW'(1) << (FRAC_BITS - 1);
    localparam logic [GW-1:0] ONE_G = GW'(1) << FRAC_BITS;
    localparam logic [GW-1:0] TWO_G = GW'(1) << (FRAC_BITS + 1);
    localparam logic [MW-1:0] ONE_M = MW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] RND   = SW'(32) << FRAC_BITS;

    logic [3:0] vld_reg;
    logic [4:0] rdy;

    logic [XW-1:0] x_reg, x_next;
    curve_kind_t   kind1_reg, kind1_next;
    logic [AW-1:0] au_reg, au_next;
    logic [1:0]    seg2_reg, seg2_next;
    curve_kind_t   kind2_reg;
    logic [SW-1:0] sq_reg;
    logic [1:0]    seg3_reg;
    curve_kind_t   kind3_reg;
    logic [GW-1:0] g_reg, g_next;

    assign rdy[4]    = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[3];
    assign curve     = g_reg;

    genvar s;
    generate
        for (s = 0; s < 4; s++)
        begin : g_vld
            assign rdy[s] = ~vld_reg[s] | rdy[s+1];
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (rdy[s])
                begin
                    vld_reg[s] <= (s == 0) ? in_valid : vld_reg[(s == 0) ? 0 : s-1];
                end
            end
        end
    endgenerate

    // Stage one: the argument of the bounce-out parabola and how to fold it.
    always_comb
    begin
        logic [GW-1:0] two_p;
        two_p = {progress, 1'b0};
        case (ease_mode)
            MODE_OUT:
            begin
                x_next     = progress;
                kind1_next = KIND_OUT_FULL;
            end
            MODE_IN:
            begin
                x_next     = ONE_G[XW-1:0] - progress;
                kind1_next = KIND_IN_FULL;
            end
            default:
            begin
                if (progress < HALF)
                begin
                    x_next     = XW'(ONE_G - two_p);
                    kind1_next = KIND_IN_HALF;
                end
                else
                begin
                    x_next     = XW'(two_p - ONE_G);
                    kind1_next = KIND_OUT_HALF;
                end
            end
        endcase
    end

    // Stage two: pick the segment from 11x and form |22x - K|.
    always_comb
    begin
        logic [MW-1:0]        x11;
        logic signed [UW-1:0] u;
        x11 = (MW'(x_reg) << 3) + (MW'(x_reg) << 1) + MW'(x_reg);
        if (x11 < (ONE_M << 2))
        begin
            seg2_next = 2'd0;
        end
        else if (x11 < (ONE_M << 3))
        begin
            seg2_next = 2'd1;
        end
        else if (x11 < ((ONE_M << 3) + (ONE_M << 1)))
        begin
            seg2_next = 2'd2;
        end
        else
        begin
            seg2_next = 2'd3;
        end
        u       = $signed({x11, 1'b0}) - $signed(UW'(bec_seg_k(seg2_next)) << FRAC_BITS);
        au_next = AW'((u < 0) ? -u : u);
    end

    // Stage four: round the square, add the segment height, fold by mode.
    always_comb
    begin
        logic [SW-1:0] sq_rnd;
        logic [GW-1:0] bo;
        sq_rnd = sq_reg + RND;
        bo     = sq_rnd[SW-1:FRAC_BITS+6]
                 + (GW'(bec_seg_offset(seg3_reg)) << (FRAC_BITS - 6));
        case (kind3_reg)
            KIND_OUT_FULL: g_next = {bo[GW-2:0], 1'b0};
            KIND_IN_FULL:  g_next = TWO_G - {bo[GW-2:0], 1'b0};
            KIND_IN_HALF:  g_next = ONE_G - bo;
            KIND_OUT_HALF: g_next = ONE_G + bo;
            default:       g_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x_reg     <= x_next;
            kind1_reg <= kind1_next;
        end
        if (rdy[1])
        begin
            au_reg    <= au_next;
            seg2_reg  <= seg2_next;
            kind2_reg <= kind1_reg;
        end
        if (rdy[2])
        begin
            sq_reg    <= au_reg * au_reg;
            seg3_reg  <= seg2_reg;
            kind3_reg <= kind2_reg;
        end
        if (rdy[3])
        begin
            g_reg <= g_next;
        end
    end

endmodule

// File: rtl/bounce_easing_curve.sv
// Bounce easing curve: one eased value for every elapsed-time item.
// The pipeline holds FRAC_BITS + 1 divider stages, four curve stages, one multiply stage and
// one rounding stage that is the output register.
// Throughput is one item per clock; every stage holds its item under back-pressure.
// rst_n is asynchronous and active low; it empties the pipeline and sets the registers
// to ease out, start 0, change 0, duration 1.
`timescale 1ns / 1ps
module bounce_easing_curve #(
    parameter int TIME_BITS  = bec_pkg::DEF_TIME_BITS,
    parameter int VALUE_BITS = bec_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = bec_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bec_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [bec_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [bec_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [TIME_BITS-1:0]              elapsed,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [VALUE_BITS:0]        eased_value
);
    import bec_pkg::*;

    `include "bounce_easing_curve_assert.svh"

    localparam int GW = FRAC_BITS + 2;
    localparam int PW = VALUE_BITS + FRAC_BITS + 3;
    localparam int QW = VALUE_BITS + 2;
    localparam logic [GW-1:0] CURVE_MAX = GW'(1) << (FRAC_BITS + 1);
    localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << FRAC_BITS;

    // Configuration registers. The host must write them only while the pipeline is empty;
    // the block itself does not enforce this, and the stages that use them read them directly.
    logic [1:0]                   ease_mode_reg;
    logic signed [VALUE_BITS-1:0] start_value_reg;
    logic signed [VALUE_BITS-1:0] change_value_reg;
    logic [TIME_BITS-1:0]         duration_reg;
    logic                         wr_en;
    reg_index_t                   reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ease_mode_reg    <= MODE_OUT;
            start_value_reg  <= '0;
            change_value_reg <= '0;
            duration_reg     <= TIME_BITS'(1);
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_EASE_MODE:    ease_mode_reg    <= pwdata[1:0];
                REG_START_VALUE:  start_value_reg  <= pwdata[VALUE_BITS-1:0];
                REG_CHANGE_VALUE: change_value_reg <= pwdata[VALUE_BITS-1:0];
                REG_DURATION:     duration_reg     <= pwdata[TIME_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Reads return the register value; the signed ones come back sign-extended.
    always_comb
    begin
        case (reg_sel)
            REG_EASE_MODE:    prdata = APB_DATA_BITS'(ease_mode_reg);
            REG_START_VALUE:  prdata = APB_DATA_BITS'(start_value_reg);
            REG_CHANGE_VALUE: prdata = APB_DATA_BITS'(change_value_reg);
            REG_DURATION:     prdata = APB_DATA_BITS'(duration_reg);
            default:          prdata = '0;
        endcase
    end

    // Progress p = floor(min(elapsed, duration) * 2^FRAC_BITS / duration),
    // one quotient bit per stage.
    logic               div_valid;
    logic               div_ready;
    logic [FRAC_BITS:0] progress;

    bec_divider #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elapsed   (elapsed),
        .duration  (duration_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .progress  (progress)
    );

    // Bounce curve in Q1.(FRAC_BITS+1), with the mode folding applied.
    logic          curve_valid;
    logic          curve_ready;
    logic [GW-1:0] curve;

    bec_curve #(
        .FRAC_BITS (FRAC_BITS)
    ) u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .progress  (progress),
        .ease_mode (ease_mode_reg),
        .out_valid (curve_valid),
        .out_ready (curve_ready),
        .curve     (curve)
    );

    // Final two stages: change times curve, then round to nearest (ties up) and add start.
    logic [1:0]            fvld_reg;
    logic [2:0]            frdy;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic [VALUE_BITS:0]   res_reg, res_next;

    assign frdy[2]     = out_ready;
    assign frdy[1]     = ~fvld_reg[1] | frdy[2];
    assign frdy[0]     = ~fvld_reg[0] | frdy[1];
    assign curve_ready = frdy[0];
    assign out_valid   = fvld_reg[1];
    assign eased_value = res_reg;

    assign prod_next = change_value_reg * $signed({1'b0, curve});

    always_comb
    begin
        logic signed [PW-1:0] sum;
        logic signed [QW-1:0] q;
        logic signed [QW-1:0] res;
        sum      = prod_reg + HALF_LSB;
        q        = sum[PW-1:FRAC_BITS+1];
        res      = q + QW'(start_value_reg);
        res_next = res[VALUE_BITS:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvld_reg <= '0;
        end
        else
        begin
            if (frdy[0])
            begin
                fvld_reg[0] <= curve_valid;
            end
            if (frdy[1])
            begin
                fvld_reg[1] <= fvld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frdy[0])
        begin
            prod_reg <= prod_next;
        end
        if (frdy[1])
        begin
            res_reg <= res_next;
        end
    end

    // The input side can only stall when every stage is full and the result is not taken.
    `BEC_ASSERT_IMP(a_backpressure, clk, rst_n, !in_ready, out_valid && !out_ready)
    // The folded curve never exceeds one in Q1.(FRAC_BITS+1).
    `BEC_ASSERT_IMP(a_curve_range, clk, rst_n, curve_valid, curve <= CURVE_MAX)
    // A curve item that the final stages refuse stays in the curve unit.
    `BEC_ASSERT_NEXT(a_curve_held, clk, rst_n, curve_valid && !curve_ready, curve_valid)
    // A write to the mode register lands in the next cycle.
    `BEC_ASSERT_NEXT(a_mode_write, clk, rst_n, wr_en && (reg_sel == REG_EASE_MODE),
                     ease_mode_reg == $past(pwdata[1:0]))

endmodule
